### hw/rtl/rwlq_pkg.sv
// Shared constants, codes and control/status types for the reader/writer lock queue.
package rwlq_pkg;

  // Default sizing
  localparam int QUEUE_DEPTH_DEF = 64;
  localparam int MAX_GROUP_DEF   = 16;
  localparam int HANDLE_BITS_DEF = 32;

  // Fixed port widths
  localparam int PORT_HANDLE_W = 32;
  localparam int PORT_RANK_W   = 16;
  localparam int PORT_SIZE_W   = 5;
  localparam int PORT_STATUS_W = 3;

  // Request kinds
  localparam logic KIND_ACQUIRE = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  // Result status codes
  localparam logic [PORT_STATUS_W-1:0] STAT_GRANTED = 3'd0;
  localparam logic [PORT_STATUS_W-1:0] STAT_QUEUED  = 3'd1;
  localparam logic [PORT_STATUS_W-1:0] STAT_FULL    = 3'd2;
  localparam logic [PORT_STATUS_W-1:0] STAT_MEMBER  = 3'd3;
  localparam logic [PORT_STATUS_W-1:0] STAT_EMPTY   = 3'd4;

  // Controller to datapath commands
  typedef struct packed {
    logic do_acquire;        // handle an acquire transaction
    logic do_release_empty;  // release with nothing queued
    logic emit_first;        // grant first member of head group
    logic emit_next;         // grant a following member
  } rwlq_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;          // result register can take a new result
    logic queue_empty;       // no queued entries
    logic first_is_last;     // head group has one member
    logic next_is_last;      // one member still to grant
  } rwlq_sts_t;

endpackage

### hw/rtl/rw_lock_request_queue_unit.sv
// Top level of the reader/writer lock request queue.
// Lock request queue for one data block. An acquire transaction is granted at
// once when the lock is free, otherwise it is queued in a ring of QUEUE_DEPTH
// entries (rejected when full); shared requests join the open shared tail
// group up to MAX_GROUP members. A release transaction frees the lock when
// nothing is queued, otherwise it grants the whole head group, one result per
// member with group size and a last mark. An acquire, or a release on an
// empty queue, gives one result. A release that grants a group reads the
// entry memory once per member; the read is registered, so after each head
// pointer move the controller waits in S_WAIT for the new head entry.
// Results leave through an output register, and the next transaction is
// taken once the final result of the previous one can be taken. Entry
// memories need no clearing after reset; only entries between head and
// tail are ever read.
module rw_lock_request_queue_unit
  import rwlq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int MAX_GROUP   = MAX_GROUP_DEF,
  parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     kind,
  input  logic [PORT_HANDLE_W-1:0] data_handle,
  input  logic [PORT_RANK_W-1:0]   requester_rank,
  input  logic                     shared_request,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [PORT_STATUS_W-1:0] status,
  output logic [PORT_HANDLE_W-1:0] granted_handle,
  output logic [PORT_RANK_W-1:0]   granted_rank,
  output logic [PORT_SIZE_W-1:0]   group_size,
  output logic                     last_of_run
);

  rwlq_cmd_t cmd;
  rwlq_sts_t sts;

  // Sequencing
  rwlq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .kind     (kind),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Queue storage and result register
  rwlq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .MAX_GROUP   (MAX_GROUP),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .data_handle    (data_handle),
    .requester_rank (requester_rank),
    .shared_request (shared_request),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .granted_handle (granted_handle),
    .granted_rank   (granted_rank),
    .group_size     (group_size),
    .last_of_run    (last_of_run)
  );

endmodule

### hw/rtl/rwlq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rwlq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

### hw/rtl/rwlq_datapath.sv
// Queue datapath: ring pointers, lock and group state, entry memories, result register.
module rwlq_datapath
  import rwlq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int MAX_GROUP   = MAX_GROUP_DEF,
  parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  rwlq_cmd_t                cmd,
  output rwlq_sts_t                sts,
  input  logic [PORT_HANDLE_W-1:0] data_handle,
  input  logic [PORT_RANK_W-1:0]   requester_rank,
  input  logic                     shared_request,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [PORT_STATUS_W-1:0] status,
  output logic [PORT_HANDLE_W-1:0] granted_handle,
  output logic [PORT_RANK_W-1:0]   granted_rank,
  output logic [PORT_SIZE_W-1:0]   group_size,
  output logic                     last_of_run
);

  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int MW = $clog2(MAX_GROUP + 1);
  localparam int EW = HANDLE_BITS + PORT_RANK_W;

  // Control state
  logic          lock_held;
  logic [IW-1:0] head;
  logic [IW-1:0] tail;
  logic [CW-1:0] count;
  logic          tail_open;
  logic [MW-1:0] tail_members;
  logic [IW-1:0] grp_start;
  logic [MW-1:0] remain;
  logic [MW-1:0] size_reg;

  // Memory ports
  logic          entry_we;
  logic [EW-1:0] entry_wdata;
  logic [EW-1:0] entry_rd;
  logic          len_we;
  logic [IW-1:0] len_waddr;
  logic [MW-1:0] len_wdata;
  logic [MW-1:0] len_rd;

  logic full;
  logic join_grp;
  logic load_out;

  function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] idx);
    ring_next = (idx == IW'(QUEUE_DEPTH - 1)) ? '0 : idx + 1'b1;
  endfunction

  // Enqueue decision
  assign full     = (count == CW'(QUEUE_DEPTH));
  assign join_grp = shared_request && tail_open && (count != '0) &&
                    (tail_members < MW'(MAX_GROUP));

  assign entry_we    = cmd.do_acquire && lock_held && !full;
  assign entry_wdata = {HANDLE_BITS'(data_handle), requester_rank};
  assign len_we      = entry_we;
  assign len_waddr   = join_grp ? grp_start : tail;
  assign len_wdata   = join_grp ? tail_members + 1'b1 : MW'(1);

  // Status to controller
  assign sts.out_free      = !out_valid || out_ready;
  assign sts.queue_empty   = (count == '0);
  assign sts.first_is_last = (len_rd == MW'(1));
  assign sts.next_is_last  = (remain == MW'(1));

  assign load_out = cmd.do_acquire || cmd.do_release_empty ||
                    cmd.emit_first || cmd.emit_next;

  // Handle and rank per entry
  rwlq_ram #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_entry_ram (
    .clk     (clk),
    .wr_en   (entry_we),
    .wr_addr (tail),
    .wr_data (entry_wdata),
    .rd_addr (head),
    .rd_data (entry_rd)
  );

  // Group length kept at each group's start entry
  rwlq_ram #(
    .WIDTH (MW),
    .DEPTH (QUEUE_DEPTH)
  ) u_len_ram (
    .clk     (clk),
    .wr_en   (len_we),
    .wr_addr (len_waddr),
    .wr_data (len_wdata),
    .rd_addr (head),
    .rd_data (len_rd)
  );

  // Lock, ring and group bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      lock_held    <= 1'b0;
      head         <= '0;
      tail         <= '0;
      count        <= '0;
      tail_open    <= 1'b0;
      tail_members <= '0;
      grp_start    <= '0;
      remain       <= '0;
      size_reg     <= '0;
    end else begin
      if (cmd.do_acquire) begin
        if (!lock_held) begin
          lock_held <= 1'b1;
        end else if (!full) begin
          tail  <= ring_next(tail);
          count <= count + 1'b1;
          if (join_grp) begin
            tail_members <= tail_members + 1'b1;
          end else begin
            grp_start    <= tail;
            tail_open    <= shared_request;
            tail_members <= MW'(1);
          end
        end
      end
      if (cmd.do_release_empty) begin
        lock_held    <= 1'b0;
        tail_open    <= 1'b0;
        tail_members <= '0;
      end
      if (cmd.emit_first || cmd.emit_next) begin
        head  <= ring_next(head);
        count <= count - 1'b1;
        if (count == CW'(1)) begin
          tail_open    <= 1'b0;
          tail_members <= '0;
        end
      end
      if (cmd.emit_first) begin
        size_reg <= len_rd;
        remain   <= len_rd - 1'b1;
      end
      if (cmd.emit_next) begin
        remain <= remain - 1'b1;
      end
    end
  end

  // Result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (load_out) begin
      if (cmd.emit_first || cmd.emit_next) begin
        status         <= STAT_MEMBER;
        granted_handle <= PORT_HANDLE_W'(entry_rd[EW-1:PORT_RANK_W]);
        granted_rank   <= entry_rd[PORT_RANK_W-1:0];
        if (cmd.emit_first) begin
          group_size  <= PORT_SIZE_W'(len_rd);
          last_of_run <= sts.first_is_last;
        end else begin
          group_size  <= PORT_SIZE_W'(size_reg);
          last_of_run <= sts.next_is_last;
        end
      end else begin
        granted_handle <= '0;
        granted_rank   <= '0;
        group_size     <= '0;
        last_of_run    <= 1'b1;
        if (cmd.do_acquire) begin
          if (!lock_held) begin
            status <= STAT_GRANTED;
          end else if (full) begin
            status <= STAT_FULL;
          end else begin
            status <= STAT_QUEUED;
          end
        end else begin
          status <= STAT_EMPTY;
        end
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    int'(count) <= QUEUE_DEPTH)
    else $error("queue count beyond depth");

  a_members_bound: assert property (@(posedge clk) disable iff (rst)
    int'(tail_members) <= MAX_GROUP)
    else $error("tail group beyond max group");

  a_ring_empty: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (head == tail))
    else $error("empty queue with head and tail apart");

  a_head_len: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_first |-> (len_rd != '0) && (int'(len_rd) <= int'(count)) &&
                       (int'(len_rd) <= MAX_GROUP))
    else $error("head group length inconsistent");

  a_drain_count: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_first || cmd.emit_next) |-> (count != '0))
    else $error("grant from empty queue");
`endif

endmodule

### hw/rtl/rwlq_ctrl.sv
// Controller state machine: input handshake and sequencing of group grants.
module rwlq_ctrl
  import rwlq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic      kind,
  input  rwlq_sts_t sts,
  output rwlq_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_FIRST,
    S_WAIT,
    S_MEMBER
  } state_t;

  state_t state;
  state_t state_next;

  // Next state and commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = (state == S_IDLE) && sts.out_free;
    case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          if (kind == KIND_ACQUIRE) begin
            cmd.do_acquire = 1'b1;
          end else if (sts.queue_empty) begin
            cmd.do_release_empty = 1'b1;
          end else begin
            state_next = S_FIRST;
          end
        end
      end
      S_FIRST: begin
        if (sts.out_free) begin
          cmd.emit_first = 1'b1;
          state_next     = sts.first_is_last ? S_IDLE : S_WAIT;
        end
      end
      // head moved: wait for the registered memory read of the new head
      S_WAIT: begin
        state_next = S_MEMBER;
      end
      S_MEMBER: begin
        if (sts.out_free) begin
          cmd.emit_next = 1'b1;
          state_next    = sts.next_is_last ? S_IDLE : S_WAIT;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### sim/rw_lock_request_queue_unit_tb.sv
// Self-checking testbench for the reader/writer lock request queue top level.
module rw_lock_request_queue_unit_tb;
  import rwlq_pkg::*;

  localparam int QDEPTH        = QUEUE_DEPTH_DEF;
  localparam int MAXG          = MAX_GROUP_DEF;
  localparam int RANDOM_ITEMS  = 360;
  localparam int LIMIT_CYCLES  = 600000;
  localparam int SETTLE_CYCLES = 40;

  // One lock response as seen on the result port
  typedef struct packed {
    logic [PORT_STATUS_W-1:0] status;
    logic [PORT_HANDLE_W-1:0] handle;
    logic [PORT_RANK_W-1:0]   rank;
    logic [PORT_SIZE_W-1:0]   size;
    logic                     last;
  } lock_resp_t;

  logic                     clk;
  logic                     rst;
  logic                     in_valid;
  logic                     in_ready;
  logic                     kind;
  logic [PORT_HANDLE_W-1:0] data_handle;
  logic [PORT_RANK_W-1:0]   requester_rank;
  logic                     shared_request;
  logic                     out_valid;
  logic                     out_ready;
  logic [PORT_STATUS_W-1:0] status;
  logic [PORT_HANDLE_W-1:0] granted_handle;
  logic [PORT_RANK_W-1:0]   granted_rank;
  logic [PORT_SIZE_W-1:0]   group_size;
  logic                     last_of_run;

  // Shared run control
  bit          steady;        // no idling on either side while set
  int          hold_left;     // receiver hold-off, in cycles
  int          mismatches;
  lock_resp_t  pending_lock_responses[$];

  // Lock queue state tracked alongside the block
  bit                       q_lock_held;
  logic [PORT_HANDLE_W-1:0] q_handle[QDEPTH];
  logic [PORT_RANK_W-1:0]   q_rank[QDEPTH];
  bit                       q_group_start[QDEPTH];
  int unsigned              q_head;
  int unsigned              q_tail;
  int unsigned              q_count;
  bit                       q_tail_open;
  int unsigned              q_tail_members;

  rw_lock_request_queue_unit dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .kind           (kind),
    .data_handle    (data_handle),
    .requester_rank (requester_rank),
    .shared_request (shared_request),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .granted_handle (granted_handle),
    .granted_rank   (granted_rank),
    .group_size     (group_size),
    .last_of_run    (last_of_run)
  );

  // Clock
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Hard stop in case the block hangs
  initial begin
    #(LIMIT_CYCLES * 20);
    $display("Mismatches found");
    $finish;
  end

  // Apply one transaction to the tracked lock state and queue its responses
  task automatic compute_lock_responses(input logic k, input logic [PORT_HANDLE_W-1:0] h,
                                        input logic [PORT_RANK_W-1:0] r, input logic sh);
    lock_resp_t  resp;
    bit          join_group;
    int unsigned members;
    int unsigned idx;
    int unsigned n;
    resp      = '0;
    resp.last = 1'b1;
    if (k == KIND_ACQUIRE) begin
      if (!q_lock_held) begin
        q_lock_held = 1'b1;
        resp.status = STAT_GRANTED;
      end else if (q_count >= QDEPTH) begin
        resp.status = STAT_FULL;
      end else begin
        join_group = sh && q_tail_open && q_count > 0 && q_tail_members < MAXG;
        q_handle[q_tail]      = h;
        q_rank[q_tail]        = r;
        q_group_start[q_tail] = !join_group;
        q_tail                = (q_tail + 1) % QDEPTH;
        q_count++;
        if (join_group) begin
          q_tail_members++;
        end else begin
          q_tail_open    = sh;
          q_tail_members = 1;
        end
        resp.status = STAT_QUEUED;
      end
      pending_lock_responses.push_back(resp);
    end else if (q_count == 0) begin
      // release with nothing queued frees the lock
      q_lock_held    = 1'b0;
      q_tail_open    = 1'b0;
      q_tail_members = 0;
      resp.status    = STAT_EMPTY;
      pending_lock_responses.push_back(resp);
    end else begin
      // measure the head group, then grant its members in order
      members = 1;
      idx     = (q_head + 1) % QDEPTH;
      while (members < q_count && members < MAXG && !q_group_start[idx]) begin
        members++;
        idx = (idx + 1) % QDEPTH;
      end
      for (n = 0; n < members; n++) begin
        resp.status = STAT_MEMBER;
        resp.handle = q_handle[q_head];
        resp.rank   = q_rank[q_head];
        resp.size   = members[PORT_SIZE_W-1:0];
        resp.last   = (n + 1 == members);
        pending_lock_responses.push_back(resp);
        q_head = (q_head + 1) % QDEPTH;
      end
      q_count -= members;
      if (q_count == 0) begin
        q_tail_open    = 1'b0;
        q_tail_members = 0;
      end
    end
  endtask

  task automatic note_mismatch(input string msg);
    mismatches++;
    $display("[%0t] %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) note_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
  endtask

  // Sender: random idle cycles with noise on the payload, then hold the
  // transaction until it is accepted. Valid is left high on return.
  task automatic send_request(input logic k, input logic [PORT_HANDLE_W-1:0] h,
                              input logic [PORT_RANK_W-1:0] r, input logic sh);
    while (!steady && $urandom_range(0, 99) < 26) begin
      in_valid       <= 1'b0;
      kind           <= 1'($urandom_range(0, 1));
      data_handle    <= $urandom;
      requester_rank <= 16'($urandom_range(0, 65535));
      shared_request <= 1'($urandom_range(0, 1));
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    kind           <= k;
    data_handle    <= h;
    requester_rank <= r;
    shared_request <= sh;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    compute_lock_responses(k, h, r, sh);
  endtask

  // Sender pause until every queued response has been seen
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_lock_responses.size() != 0);
  endtask

  task automatic release_until_free();
    while (q_lock_held || q_count != 0)
      send_request(KIND_RELEASE, $urandom, 16'($urandom_range(0, 65535)),
                   1'($urandom_range(0, 1)));
  endtask

  // Receiver: random stalls, long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (steady) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= 26);
      end
    end
  end

  // Result checker: each accepted transaction against the oldest expectation
  initial begin
    lock_resp_t want;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        if (pending_lock_responses.size() == 0) begin
          note_mismatch($sformatf("unexpected result status %0d", status));
        end else begin
          want = pending_lock_responses.pop_front();
          check_field("status", 32'(status), 32'(want.status));
          check_field("granted_handle", granted_handle, want.handle);
          check_field("granted_rank", 32'(granted_rank), 32'(want.rank));
          check_field("group_size", 32'(group_size), 32'(want.size));
          check_field("last_of_run", 32'(last_of_run), 32'(want.last));
        end
      end
    end
  end

  // Free lock, grant, queue, join, close, and empty releases
  task automatic test_basic_sequence();
    send_request(KIND_RELEASE, '1, '1, 1'b1);             // release with lock already free
    send_request(KIND_ACQUIRE, '0, '0, 1'b0);             // granted at once
    send_request(KIND_ACQUIRE, '1, '1, 1'b1);             // opens shared group
    send_request(KIND_ACQUIRE, 32'h5a5a_a5a5, 16'h8001, 1'b1); // joins it
    send_request(KIND_ACQUIRE, 32'h8000_0001, 16'h7ffe, 1'b0); // exclusive group
    send_request(KIND_ACQUIRE, 32'h0000_ffff, 16'h00ff, 1'b1); // tail closed: new group
    send_request(KIND_RELEASE, '0, '0, 1'b0);             // grants group of two
    send_request(KIND_RELEASE, '1, '1, 1'b0);             // grants exclusive member
    send_request(KIND_RELEASE, '0, '0, 1'b1);             // drains tail group
    send_request(KIND_ACQUIRE, 32'hffff_0000, 16'hff00, 1'b1); // new group after drain
    send_request(KIND_ACQUIRE, 32'h1234_5678, 16'h1234, 1'b1);
    send_request(KIND_RELEASE, '0, '0, 1'b0);
    send_request(KIND_RELEASE, '0, '0, 1'b0);             // empty: lock freed
    send_request(KIND_RELEASE, '0, '0, 1'b0);
  endtask

  // Shared group reaches its member limit and the next one starts a new group
  task automatic test_group_limit();
    int n;
    send_request(KIND_ACQUIRE, $urandom, 16'($urandom_range(0, 65535)), 1'b1);
    for (n = 0; n < MAXG + 2; n++)
      send_request(KIND_ACQUIRE, $urandom, 16'($urandom_range(0, 65535)), 1'b1);
    release_until_free();
  endtask

  // Receiver holds off while the sender keeps offering, then the ring fills
  task automatic test_full_queue_backpressure();
    int n;
    hold_left = 400;
    send_request(KIND_ACQUIRE, $urandom, 16'($urandom_range(0, 65535)),
                 1'($urandom_range(0, 1)));
    for (n = 0; n < QDEPTH + 3; n++)
      send_request(KIND_ACQUIRE, $urandom, 16'($urandom_range(0, 65535)),
                   $urandom_range(0, 99) < 60);
    release_until_free();
  endtask

  // Random phases of acquire and shared bias, with a stretch of no idling
  task automatic test_random_traffic();
    int   n;
    int   acq_pct;
    int   shr_pct;
    logic k;
    acq_pct = 50;
    shr_pct = 50;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(0, 3))
          0: acq_pct = 50;
          1: acq_pct = 70;
          2: acq_pct = 85;
          default: acq_pct = 95;
        endcase
        case ($urandom_range(0, 3))
          0: shr_pct = 0;
          1: shr_pct = 40;
          2: shr_pct = 80;
          default: shr_pct = 100;
        endcase
        steady = (n >= 240 && n < 320);
      end
      if (n % 120 == 119) wait_drained();
      k = ($urandom_range(0, 99) < acq_pct) ? KIND_ACQUIRE : KIND_RELEASE;
      send_request(k, $urandom, 16'($urandom_range(0, 65535)),
                   $urandom_range(0, 99) < shr_pct);
    end
    steady = 1'b0;
  endtask

  // Main sequence
  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    kind           = KIND_ACQUIRE;
    data_handle    = '0;
    requester_rank = '0;
    shared_request = 1'b0;
    steady         = 1'b0;
    hold_left      = 0;
    mismatches     = 0;
    q_lock_held    = 1'b0;
    q_head         = 0;
    q_tail         = 0;
    q_count        = 0;
    q_tail_open    = 1'b0;
    q_tail_members = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_basic_sequence();
    wait_drained();
    test_group_limit();
    wait_drained();
    test_full_queue_backpressure();
    wait_drained();
    test_random_traffic();
    wait_drained();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
